/* hdl/hpt_pkg.sv */
package hpt_pkg;

   // Field widths
   localparam int WORD_W    = 32;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;
   localparam int INDEX_W   = 4;
   localparam int DIM       = 4;
   localparam int ENTRIES   = DIM * DIM;

   // Default fraction width of the Q format
   localparam int FRAC_BITS_DEFAULT = 16;

   // Result queue: enough entries to cover the lane pipeline plus output turnaround
   localparam int RESULT_DEPTH = 8;
   localparam int PTR_W        = $clog2(RESULT_DEPTH);
   localparam int CREDIT_W     = PTR_W + 1;

   // Opcodes
   localparam logic OPCODE_WRITE     = 1'b0;
   localparam logic OPCODE_TRANSFORM = 1'b1;

   typedef logic signed [WORD_W-1:0] word_type;

   // One row result leaving a lane
   typedef struct packed {
      word_type value;
      logic     clip;
   } lane_result_type;

   // One queued output transaction
   typedef struct packed {
      word_type out_x;
      word_type out_y;
      word_type out_z;
      word_type out_w;
      logic     saturated;
   } result_entry_type;

   // Queue control from the top level
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

endpackage

/* hdl/hpt_lane.sv */
module hpt_lane
   import hpt_pkg::*;
#(
   parameter int FracBits = FRAC_BITS_DEFAULT
) (
   input  logic            clock,
   input  word_type        coef  [DIM],
   input  word_type        point [DIM],
   output lane_result_type result
);

   logic signed [PROD_W-1:0] prod_ff [DIM];
   logic signed [PROD_W-1:0] prod_in [DIM];
   logic signed [PAIR_W-1:0] pair_ff [2];
   logic signed [PAIR_W-1:0] pair_in [2];
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  shifted;
   logic [SUM_W-WORD_W:0]    upper;

   // Stage 1: one multiplier per column
   always_comb begin
      for (int j = 0; j < DIM; j++) begin
         prod_in[j] = PROD_W'(coef[j]) * PROD_W'(point[j]);
      end
   end

   // Stage 2: pairwise sums
   always_comb begin
      pair_in[0] = PAIR_W'(prod_ff[0]) + PAIR_W'(prod_ff[1]);
      pair_in[1] = PAIR_W'(prod_ff[2]) + PAIR_W'(prod_ff[3]);
   end

   // Stage 3: full exact row sum
   assign sum_in = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pair_ff <= pair_in;
      sum_ff  <= sum_in;
   end

   // Floor shift and clip to the word range
   assign shifted = sum_ff >>> FracBits;
   assign upper   = shifted[SUM_W-1:WORD_W-1];

   always_comb begin
      if (upper == '0 || upper == '1) begin
         result.value = shifted[WORD_W-1:0];
         result.clip  = 1'b0;
      end else if (shifted[SUM_W-1]) begin
         result.value = {1'b1, {(WORD_W-1){1'b0}}};
         result.clip  = 1'b1;
      end else begin
         result.value = {1'b0, {(WORD_W-1){1'b1}}};
         result.clip  = 1'b1;
      end
   end

endmodule

/* hdl/hpt_merge.sv */
module hpt_merge
   import hpt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_ctrl_type   ctrl,
   input  lane_result_type  lane_result [DIM],
   output logic             not_empty,
   output result_entry_type head
);

   result_entry_type entry_ff [RESULT_DEPTH];
   result_entry_type entry_in;
   logic [PTR_W:0]   wr_ptr_ff;
   logic [PTR_W:0]   wr_ptr_in;
   logic [PTR_W:0]   rd_ptr_ff;
   logic [PTR_W:0]   rd_ptr_in;

   // Gather the four rows and fold the clip flags together
   always_comb begin
      entry_in.out_x     = lane_result[0].value;
      entry_in.out_y     = lane_result[1].value;
      entry_in.out_z     = lane_result[2].value;
      entry_in.out_w     = lane_result[3].value;
      entry_in.saturated = lane_result[0].clip | lane_result[1].clip |
                           lane_result[2].clip | lane_result[3].clip;
   end

   // Pointer update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + (PTR_W+1)'(ctrl.push);
      rd_ptr_in = rd_ptr_ff + (PTR_W+1)'(ctrl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         entry_ff[wr_ptr_ff[PTR_W-1:0]] <= entry_in;
      end
   end

   assign not_empty = (wr_ptr_ff != rd_ptr_ff);
   assign head      = entry_ff[rd_ptr_ff[PTR_W-1:0]];

endmodule

/* hdl/homogeneous_point_transform_unit.sv */
// Homogeneous point transform: out = M * (x, y, z, w), signed fixed point.
// Input channel (req_*): opcode write stores req_entry_value into matrix
// entry req_entry_index (row * 4 + column) and gives no response; opcode
// transform multiplies the point by the stored matrix. Response channel
// (rsp_*): the four row dot products, each floor-shifted by FracBits and
// clipped to 32 bits, plus a flag set when any row was clipped.
// Throughput: one transaction per cycle while req_ready is high, writes
// and transforms mixed freely. A transform's products, pair sums and row
// sums are registered in turn, then queued, raising rsp_valid. Four row lanes
// each hold four multipliers, a pairwise adder stage and a final adder stage.
// A write takes effect for any transform accepted after it.
// Stalls: results queue in an eight-entry buffer; req_ready drops once eight
// transforms are in flight or waiting, so nothing is ever lost. With
// rsp_ready held high the block never stalls the sender.
// Reset: synchronous, active high; clears the matrix to zero and empties the
// response queue. The block accepts transactions in the first cycle after it.
module homogeneous_point_transform_unit
   import hpt_pkg::*;
#(
   parameter int FracBits = FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [0:0]         req_opcode,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  word_type           req_entry_value,
   input  word_type           req_in_x,
   input  word_type           req_in_y,
   input  word_type           req_in_z,
   input  word_type           req_in_w,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output word_type           rsp_out_x,
   output word_type           rsp_out_y,
   output word_type           rsp_out_z,
   output word_type           rsp_out_w,
   output logic               rsp_saturated
);

   word_type              matrix_ff [ENTRIES];
   word_type              point     [DIM];
   logic                  req_fire;
   logic                  xform_fire;
   logic                  write_fire;
   logic                  rsp_fire;
   logic [2:0]            valid_ff;
   logic [2:0]            valid_in;
   logic [CREDIT_W-1:0]   credit_ff;
   logic [CREDIT_W-1:0]   credit_in;
   lane_result_type       lane_result [DIM];
   queue_ctrl_type        queue_ctrl;
   result_entry_type      head;

   // Handshakes
   assign req_ready  = (credit_ff < CREDIT_W'(RESULT_DEPTH));
   assign req_fire   = req_valid & req_ready;
   assign xform_fire = req_fire & (req_opcode == OPCODE_TRANSFORM);
   assign write_fire = req_fire & (req_opcode == OPCODE_WRITE);
   assign rsp_fire   = rsp_valid & rsp_ready;

   // Matrix store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            matrix_ff[i] <= '0;
         end
      end else if (write_fire) begin
         matrix_ff[req_entry_index] <= req_entry_value;
      end
   end

   // Valid tags follow the lane stages
   assign valid_in = {valid_ff[1:0], xform_fire};

   // Transforms in flight or waiting in the queue
   assign credit_in = credit_ff + CREDIT_W'(xform_fire) - CREDIT_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         credit_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         credit_ff <= credit_in;
      end
   end

   assign point[0] = req_in_x;
   assign point[1] = req_in_y;
   assign point[2] = req_in_z;
   assign point[3] = req_in_w;

   // One lane per matrix row
   for (genvar r = 0; r < DIM; r++) begin : g_lane
      word_type row_coef [DIM];

      for (genvar c = 0; c < DIM; c++) begin : g_coef
         assign row_coef[c] = matrix_ff[r * DIM + c];
      end

      hpt_lane #(
         .FracBits (FracBits)
      ) u_lane (
         .clock  (clock),
         .coef   (row_coef),
         .point  (point),
         .result (lane_result[r])
      );
   end

   // Merge rows into the response queue
   assign queue_ctrl.push = valid_ff[2];
   assign queue_ctrl.pop  = rsp_fire;

   hpt_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (queue_ctrl),
      .lane_result (lane_result),
      .not_empty   (rsp_valid),
      .head        (head)
   );

   assign rsp_out_x     = head.out_x;
   assign rsp_out_y     = head.out_y;
   assign rsp_out_z     = head.out_z;
   assign rsp_out_w     = head.out_w;
   assign rsp_saturated = head.saturated;

endmodule

/* tb/homogeneous_point_transform_unit_tb.sv */
module homogeneous_point_transform_unit_tb;
   import hpt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC        = FRAC_BITS_DEFAULT;
   localparam int PHASE_ITEMS = 250;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 20;

   localparam logic signed [127:0] SUM_MAX = 128'sh7FFF_FFFF;
   localparam logic signed [127:0] SUM_MIN = -128'sh8000_0000;

   // One input transaction as queued for the driver
   typedef struct packed {
      logic [0:0]         opcode;
      logic [INDEX_W-1:0] entry_index;
      word_type           entry_value;
      word_type           in_x;
      word_type           in_y;
      word_type           in_z;
      word_type           in_w;
   } point_request_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [0:0]         req_opcode = OPCODE_WRITE;
   logic [INDEX_W-1:0] req_entry_index = '0;
   word_type           req_entry_value = '0;
   word_type           req_in_x = '0;
   word_type           req_in_y = '0;
   word_type           req_in_z = '0;
   word_type           req_in_w = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   word_type           rsp_out_x;
   word_type           rsp_out_y;
   word_type           rsp_out_z;
   word_type           rsp_out_w;
   logic               rsp_saturated;

   point_request_type queued_requests[$];
   result_entry_type  predicted_outputs[$];
   word_type          coeff_mirror[ENTRIES];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   logic        hold_req       = 1'b0;
   int unsigned hold_count     = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned errors         = 0;

   homogeneous_point_transform_unit #(
      .FracBits(FRAC)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_entry_index(req_entry_index),
      .req_entry_value(req_entry_value),
      .req_in_x       (req_in_x),
      .req_in_y       (req_in_y),
      .req_in_z       (req_in_z),
      .req_in_w       (req_in_w),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_out_w      (rsp_out_w),
      .rsp_saturated  (rsp_saturated)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Matrix times point: exact sums, floor shift, clip to 32 bits
   function automatic result_entry_type transform_point(word_type x, word_type y,
                                                         word_type z, word_type w);
      result_entry_type  res;
      word_type          pt[DIM];
      word_type          row_val[DIM];
      logic signed [127:0] acc;
      logic signed [127:0] coeff;
      logic signed [127:0] comp;
      logic              clip;
      pt[0] = x;
      pt[1] = y;
      pt[2] = z;
      pt[3] = w;
      clip  = 1'b0;
      for (int r = 0; r < DIM; r++) begin
         acc = '0;
         for (int c = 0; c < DIM; c++) begin
            coeff = coeff_mirror[r * DIM + c];
            comp  = pt[c];
            acc   = acc + coeff * comp;
         end
         acc = acc >>> FRAC;
         if (acc > SUM_MAX) begin
            acc  = SUM_MAX;
            clip = 1'b1;
         end else if (acc < SUM_MIN) begin
            acc  = SUM_MIN;
            clip = 1'b1;
         end
         row_val[r] = acc[WORD_W-1:0];
      end
      res.out_x     = row_val[0];
      res.out_y     = row_val[1];
      res.out_z     = row_val[2];
      res.out_w     = row_val[3];
      res.saturated = clip;
      return res;
   endfunction

   // Mix of full-range, small Q16.16 and corner values
   function automatic word_type pick_word();
      int unsigned kind;
      int unsigned corner;
      kind = $urandom_range(9, 0);
      if (kind < 4) begin
         return $urandom;
      end else if (kind < 8) begin
         return word_type'($urandom_range(32'h7FFFF, 0)) - 32'sh40000;
      end
      corner = $urandom_range(5, 0);
      case (corner)
         0: return 32'sh7FFF_FFFF;
         1: return -32'sh7FFF_FFFF - 1;
         2: return 32'sh0;
         3: return 32'sh1_0000;
         4: return -32'sh1_0000;
         default: return -32'sh1;
      endcase
   endfunction

   function automatic point_request_type make_write(int unsigned idx, word_type val);
      point_request_type item;
      item.opcode      = OPCODE_WRITE;
      item.entry_index = idx[INDEX_W-1:0];
      item.entry_value = val;
      // point fields carry junk, the block must ignore them
      item.in_x        = pick_word();
      item.in_y        = pick_word();
      item.in_z        = pick_word();
      item.in_w        = pick_word();
      return item;
   endfunction

   function automatic point_request_type make_point(word_type x, word_type y,
                                                     word_type z, word_type w);
      point_request_type item;
      item.opcode      = OPCODE_TRANSFORM;
      item.entry_index = INDEX_W'($urandom_range(ENTRIES - 1, 0));
      item.entry_value = pick_word();
      item.in_x        = x;
      item.in_y        = y;
      item.in_z        = z;
      item.in_w        = w;
      return item;
   endfunction

   function automatic point_request_type random_request();
      word_type w;
      if ($urandom_range(9, 0) < 3) begin
         return make_write($urandom_range(ENTRIES - 1, 0), pick_word());
      end
      // homogeneous coordinate is one in about three of ten points, random otherwise
      w = ($urandom_range(9, 0) < 3) ? 32'sh1_0000 : pick_word();
      return make_point(pick_word(), pick_word(), pick_word(), w);
   endfunction

   // Driver: prediction on acceptance, then present the next transaction
   always @(posedge clock) begin : drive
      point_request_type item;
      logic              fire;
      if (reset) begin
         req_valid <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            coeff_mirror[i] = '0;
         end
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            if (req_opcode == OPCODE_WRITE) begin
               coeff_mirror[req_entry_index] = req_entry_value;
            end else begin
               predicted_outputs.push_back(
                  transform_point(req_in_x, req_in_y, req_in_z, req_in_w));
            end
         end
         if (!req_valid || fire) begin
            if (queued_requests.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               item = queued_requests.pop_front();
               req_valid       <= 1'b1;
               req_opcode      <= item.opcode;
               req_entry_index <= item.entry_index;
               req_entry_value <= item.entry_value;
               req_in_x        <= item.in_x;
               req_in_y        <= item.in_y;
               req_in_z        <= item.in_z;
               req_in_w        <= item.in_w;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string fname, logic [WORD_W-1:0] want,
                              logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
         errors++;
      end
   endtask

   // Monitor: compare each response with the oldest prediction
   always @(posedge clock) begin : watch
      result_entry_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_outputs.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %h %h %h %h %b",
                        $time, rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w, rsp_saturated);
               errors++;
            end else begin
               want = predicted_outputs.pop_front();
               check_field("out_x", want.out_x, rsp_out_x);
               check_field("out_y", want.out_y, rsp_out_y);
               check_field("out_z", want.out_z, rsp_out_z);
               check_field("out_w", want.out_w, rsp_out_w);
               check_field("saturated", WORD_W'(want.saturated), WORD_W'(rsp_saturated));
            end
         end
         // long hold-off so the result buffer fills and backs up the input
         if (hold_req && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: cycles with work owed but no transaction on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (queued_requests.size() == 0 && !req_valid && predicted_outputs.size() == 0)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no progress in %0d cycles", $time, STALL_LIMIT);
            $display("FAIL homogeneous_point_transform_unit");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (queued_requests.size() > 0 || req_valid || predicted_outputs.size() > 0);
   endtask

   task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, logic hold);
      @(negedge clock);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         queued_requests.push_back(random_request());
      end
      if (hold) begin
         hold_req = 1'b1;
      end
      wait_drained();
   endtask

   // Stimulus sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // cleared matrix gives zero
      queued_requests.push_back(make_point(32'sh1_0000, -32'sh7FFF_FFFF - 1,
                                           32'sh7FFF_FFFF, 32'sh1_0000));
      // identity, extremes pass straight through
      for (int i = 0; i < DIM; i++) begin
         queued_requests.push_back(make_write(i * DIM + i, 32'sh1_0000));
      end
      queued_requests.push_back(make_point(32'sh7FFF_FFFF, -32'sh7FFF_FFFF - 1,
                                           32'sh1, -32'sh1));
      // positive and negative clipping on row zero
      queued_requests.push_back(make_write(0, 32'sh7FFF_FFFF));
      queued_requests.push_back(make_point(32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'sh0));
      queued_requests.push_back(make_point(-32'sh7FFF_FFFF - 1, 32'sh0, 32'sh0, 32'sh0));
      // floor rounding of a tiny negative product
      queued_requests.push_back(make_write(5, -32'sh1));
      queued_requests.push_back(make_point(32'sh0, 32'sh1, 32'sh0, 32'sh0));
      // most negative squared, then a row sum past 64 bits
      queued_requests.push_back(make_write(15, -32'sh7FFF_FFFF - 1));
      queued_requests.push_back(make_point(32'sh0, 32'sh0, 32'sh0, -32'sh7FFF_FFFF - 1));
      for (int i = 12; i < 15; i++) begin
         queued_requests.push_back(make_write(i, -32'sh7FFF_FFFF - 1));
      end
      queued_requests.push_back(make_point(-32'sh7FFF_FFFF - 1, -32'sh7FFF_FFFF - 1,
                                           -32'sh7FFF_FFFF - 1, -32'sh7FFF_FFFF - 1));
      queued_requests.push_back(make_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                           32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      queued_requests.push_back(make_write(10, 32'sh7FFF_FFFF));
      queued_requests.push_back(make_point(32'sh3_0000, -32'sh2_8000, 32'sh1_0000,
                                           32'sh1_0000));
      wait_drained();

      // random phases with different idling patterns
      run_phase(0, 0, 1'b0);
      run_phase(87, 0, 1'b0);
      run_phase(0, 87, 1'b0);
      run_phase(31, 31, 1'b0);
      run_phase(0, 0, 1'b1);

      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("PASS homogeneous_point_transform_unit");
      end else begin
         $display("FAIL homogeneous_point_transform_unit");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/hpt_pkg.sv
hdl/hpt_lane.sv
hdl/hpt_merge.sv
hdl/homogeneous_point_transform_unit.sv
tb/homogeneous_point_transform_unit_tb.sv
